// ----- rtl/igc_pkg.sv -----
// Shared types and constants for the greedy graph coloring block.
// Used by igc_engine and iterative_greedy_graph_coloring_top; no dependencies.
package igc_pkg;

  localparam int OP_W        = 3;
  localparam int VAL_W       = 14;
  localparam int VCNT_W      = 11;
  localparam int PAL_W       = 7;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_COLOR_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ROW_END  = 3'd0,
    OP_NEIGHBOR = 3'd1,
    OP_ORDER    = 3'd2,
    OP_RUN      = 3'd3,
    OP_READ     = 3'd4
  } igc_op_t;

  typedef enum logic {
    CFG_VERTEX_COUNT = 1'b0,
    CFG_PALETTE_SIZE = 1'b1
  } igc_cfg_idx_t;

  typedef enum logic {
    RES_RUN_DONE = 1'b0,
    RES_READ     = 1'b1
  } igc_kind_t;

  typedef struct packed {
    logic [VCNT_W-1:0] vertex_count;
    logic [PAL_W-1:0]  palette_size;
  } igc_cfg_t;

  typedef struct packed {
    igc_kind_t              kind;
    logic [OUT_COLOR_W-1:0] vertex_color;
    logic [OUT_COLOR_W-1:0] color_count;
    logic                   overflow;
  } igc_result_t;

endpackage

// ----- rtl/iterative_greedy_graph_coloring_top.sv -----
// Top level of the greedy first-fit graph coloring block: configuration
// registers and the coloring engine. Depends on igc_pkg and igc_engine.
//
// channel   handshake              payload
// -------   ---------------------  ------------------------------------------
// in        start / busy           in_operation, in_value
// out       out_valid (strobe)     out_result_kind, out_vertex_color,
//                                  out_color_count, out_overflow
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Load requests are taken while idle and may follow back to back; a read returns its color
// through the color RAM read register and the result register. A run is a color clear pass,
// the order walk (N entries, V visited), neighbor reads (E), color probes (P), a final sweep.
// After reset a clear pass over all MAX_VERTICES color entries runs with busy high.
// Results cannot be stalled; each is shown for one cycle.
module iterative_greedy_graph_coloring_top
  import igc_pkg::*;
#(
  parameter int MAX_VERTICES     = 1024,
  parameter int MAX_EDGE_ENTRIES = 8192,
  parameter int MAX_PALETTE      = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [VAL_W-1:0]       in_value,
  output logic                   out_valid,
  output logic                   out_result_kind,
  output logic [OUT_COLOR_W-1:0] out_vertex_color,
  output logic [OUT_COLOR_W-1:0] out_color_count,
  output logic                   out_overflow,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  igc_cfg_t    cfg_r;
  igc_result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertex_count <= VCNT_W'(1024);
      cfg_r.palette_size <= PAL_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (igc_cfg_idx_t'(cfg_index))
        CFG_VERTEX_COUNT: cfg_r.vertex_count <= cfg_data[VCNT_W-1:0];
        CFG_PALETTE_SIZE: cfg_r.palette_size <= cfg_data[PAL_W-1:0];
      endcase
    end
  end

  igc_engine #(
    .MAX_VERTICES    (MAX_VERTICES),
    .MAX_EDGE_ENTRIES(MAX_EDGE_ENTRIES),
    .MAX_PALETTE     (MAX_PALETTE)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .op       (in_operation),
    .value    (in_value),
    .cfg      (cfg_r),
    .busy     (busy),
    .res_valid(out_valid),
    .res      (res)
  );

  assign out_result_kind  = res.kind;
  assign out_vertex_color = res.vertex_color;
  assign out_color_count  = res.color_count;
  assign out_overflow     = res.overflow;

endmodule

// ----- rtl/igc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module igc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/igc_engine.sv -----
// Graph stores, color store and the coloring sequencer with its compare unit.
// Depends on igc_pkg and igc_ram.
module igc_engine
  import igc_pkg::*;
#(
  parameter int MAX_VERTICES     = 1024,
  parameter int MAX_EDGE_ENTRIES = 8192,
  parameter int MAX_PALETTE      = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [OP_W-1:0]  op,
  input  logic [VAL_W-1:0] value,
  input  igc_cfg_t         cfg,
  output logic             busy,
  output logic             res_valid,
  output igc_result_t      res
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int CNTW   = $clog2(MAX_VERTICES + 1);
  localparam int EW     = $clog2(MAX_EDGE_ENTRIES);
  localparam int ECNTW  = $clog2(MAX_EDGE_ENTRIES + 1);
  localparam int PAW    = $clog2(MAX_PALETTE);
  localparam int CW     = $clog2(MAX_PALETTE + 1);

  localparam logic [CW-1:0]    UNCOLORED = CW'(MAX_PALETTE);
  localparam logic [CNTW-1:0]  VMAX      = CNTW'(MAX_VERTICES);
  localparam logic [CNTW-1:0]  VLAST     = CNTW'(MAX_VERTICES - 1);
  localparam logic [ECNTW-1:0] EMAX      = ECNTW'(MAX_EDGE_ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_OUT, S_V_ORD, S_V_CHK, S_V_END0, S_V_END1,
    S_N_ADJ, S_N_COL, S_N_STAMP, S_S_RD, S_S_CHK, S_SWEEP, S_SWEEP_END
  } state_t;

  function automatic logic [ECNTW-1:0] sat_end(input logic [VAL_W-1:0] e);
    if (32'(e) > MAX_EDGE_ENTRIES) begin
      return EMAX;
    end
    return ECNTW'(e);
  endfunction

  state_t            state_r, state_nxt;
  logic              run_r, run_nxt;
  logic [CNTW-1:0]   idx_r, idx_nxt;
  logic [CNTW-1:0]   row_cnt_r, row_cnt_nxt;
  logic [ECNTW-1:0]  edge_cnt_r, edge_cnt_nxt;
  logic [CNTW-1:0]   ord_cnt_r, ord_cnt_nxt;
  logic [MAX_PALETTE-1:0] stamp_vld_r, stamp_vld_nxt;
  logic              sweep_vld_r, sweep_vld_nxt;
  logic              res_valid_r, res_valid_nxt;
  igc_result_t       res_r, res_nxt;

  logic [CNTW-1:0]   i_r, i_nxt;
  logic [VW-1:0]     v_r, v_nxt;
  logic [ECNTW-1:0]  k_r, k_nxt;
  logic [ECNTW-1:0]  end_r, end_nxt;
  logic [CW-1:0]     c_r, c_nxt;
  logic [CW-1:0]     top_r, top_nxt;
  logic              over_r, over_nxt;
  logic              rd_oob_r, rd_oob_nxt;

  logic [CNTW-1:0]   n_eff;
  logic [CW-1:0]     pal_eff;

  logic              row_we, adj_we, ord_we, col_we, stamp_we;
  logic [VW-1:0]     row_waddr, row_raddr, ord_waddr, ord_raddr;
  logic [VW-1:0]     col_waddr, col_raddr;
  logic [EW-1:0]     adj_waddr, adj_raddr;
  logic [PAW-1:0]    stamp_waddr, stamp_raddr;
  logic [CW-1:0]     col_wdata;
  logic [VAL_W-1:0]  row_rdata, adj_rdata, ord_rdata;
  logic [CW-1:0]     col_rdata;
  logic [VW-1:0]     stamp_rdata;

  always_comb begin
    if (32'(cfg.vertex_count) > MAX_VERTICES) begin
      n_eff = VMAX;
    end else begin
      n_eff = CNTW'(cfg.vertex_count);
    end
    if (cfg.palette_size == '0) begin
      pal_eff = CW'(1);
    end else if (32'(cfg.palette_size) > MAX_PALETTE) begin
      pal_eff = UNCOLORED;
    end else begin
      pal_eff = CW'(cfg.palette_size);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    idx_nxt       = idx_r;
    row_cnt_nxt   = row_cnt_r;
    edge_cnt_nxt  = edge_cnt_r;
    ord_cnt_nxt   = ord_cnt_r;
    stamp_vld_nxt = stamp_vld_r;
    sweep_vld_nxt = 1'b0;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    i_nxt         = i_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    end_nxt       = end_r;
    c_nxt         = c_r;
    top_nxt       = top_r;
    over_nxt      = over_r;
    rd_oob_nxt    = rd_oob_r;

    row_we      = 1'b0;
    adj_we      = 1'b0;
    ord_we      = 1'b0;
    col_we      = 1'b0;
    stamp_we    = 1'b0;
    row_waddr   = row_cnt_r[VW-1:0];
    adj_waddr   = edge_cnt_r[EW-1:0];
    ord_waddr   = ord_cnt_r[VW-1:0];
    col_waddr   = v_r;
    col_wdata   = c_r;
    stamp_waddr = col_rdata[PAW-1:0];
    row_raddr   = v_r;
    adj_raddr   = k_r[EW-1:0];
    ord_raddr   = i_r[VW-1:0];
    col_raddr   = idx_r[VW-1:0];
    stamp_raddr = c_r[PAW-1:0];

    // running maximum over the final color sweep
    if (sweep_vld_r && col_rdata < UNCOLORED && col_rdata >= top_r) begin
      top_nxt = col_rdata + CW'(1);
    end

    unique case (state_r)
      S_CLEAR: begin
        col_we    = 1'b1;
        col_waddr = idx_r[VW-1:0];
        col_wdata = UNCOLORED;
        if (idx_r == VLAST) begin
          idx_nxt   = '0;
          i_nxt     = '0;
          state_nxt = run_r ? S_V_ORD : S_IDLE;
        end else begin
          idx_nxt = idx_r + CNTW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_ROW_END: begin
              if (row_cnt_r != VMAX) begin
                row_we      = 1'b1;
                row_cnt_nxt = row_cnt_r + CNTW'(1);
              end
            end
            OP_NEIGHBOR: begin
              if (edge_cnt_r != EMAX) begin
                adj_we       = 1'b1;
                edge_cnt_nxt = edge_cnt_r + ECNTW'(1);
              end
            end
            OP_ORDER: begin
              if (ord_cnt_r != VMAX) begin
                ord_we      = 1'b1;
                ord_cnt_nxt = ord_cnt_r + CNTW'(1);
              end
            end
            OP_RUN: begin
              run_nxt       = 1'b1;
              idx_nxt       = '0;
              stamp_vld_nxt = '0;
              over_nxt      = 1'b0;
              top_nxt       = '0;
              state_nxt     = S_CLEAR;
            end
            OP_READ: begin
              col_raddr  = value[VW-1:0];
              rd_oob_nxt = !(32'(value) < MAX_VERTICES);
              state_nxt  = S_RD_OUT;
            end
            default: ;
          endcase
        end
      end
      S_RD_OUT: begin
        res_valid_nxt        = 1'b1;
        res_nxt.kind         = RES_READ;
        res_nxt.vertex_color = OUT_COLOR_W'(rd_oob_r ? UNCOLORED : col_rdata);
        res_nxt.color_count  = '0;
        res_nxt.overflow     = 1'b0;
        state_nxt            = S_IDLE;
      end
      S_V_ORD: begin
        if (i_r == n_eff) begin
          idx_nxt   = '0;
          state_nxt = S_SWEEP;
        end else begin
          state_nxt = S_V_CHK;
        end
      end
      S_V_CHK: begin
        if (32'(ord_rdata) >= 32'(n_eff)) begin
          i_nxt     = i_r + CNTW'(1);
          state_nxt = S_V_ORD;
        end else begin
          v_nxt     = ord_rdata[VW-1:0];
          row_raddr = ord_rdata[VW-1:0] - VW'(1);
          state_nxt = S_V_END0;
        end
      end
      S_V_END0: begin
        k_nxt     = (v_r == '0) ? '0 : sat_end(row_rdata);
        row_raddr = v_r;
        state_nxt = S_V_END1;
      end
      S_V_END1: begin
        end_nxt   = sat_end(row_rdata);
        state_nxt = S_N_ADJ;
      end
      S_N_ADJ: begin
        if (k_r >= end_r) begin
          c_nxt     = '0;
          state_nxt = S_S_RD;
        end else begin
          state_nxt = S_N_COL;
        end
      end
      S_N_COL: begin
        k_nxt = k_r + ECNTW'(1);
        if (32'(adj_rdata) >= 32'(n_eff)) begin
          state_nxt = S_N_ADJ;
        end else begin
          col_raddr = adj_rdata[VW-1:0];
          state_nxt = S_N_STAMP;
        end
      end
      S_N_STAMP: begin
        if (col_rdata < pal_eff) begin
          stamp_we = 1'b1;
          stamp_vld_nxt[col_rdata[PAW-1:0]] = 1'b1;
        end
        state_nxt = S_N_ADJ;
      end
      S_S_RD: begin
        if (c_r == pal_eff) begin
          col_we    = 1'b1;
          col_wdata = UNCOLORED;
          over_nxt  = 1'b1;
          i_nxt     = i_r + CNTW'(1);
          state_nxt = S_V_ORD;
        end else begin
          state_nxt = S_S_CHK;
        end
      end
      S_S_CHK: begin
        if (stamp_vld_r[c_r[PAW-1:0]] && stamp_rdata == i_r[VW-1:0]) begin
          c_nxt     = c_r + CW'(1);
          state_nxt = S_S_RD;
        end else begin
          col_we    = 1'b1;
          i_nxt     = i_r + CNTW'(1);
          state_nxt = S_V_ORD;
        end
      end
      S_SWEEP: begin
        sweep_vld_nxt = 1'b1;
        if (idx_r == VLAST) begin
          idx_nxt   = '0;
          state_nxt = S_SWEEP_END;
        end else begin
          idx_nxt = idx_r + CNTW'(1);
        end
      end
      S_SWEEP_END: begin
        res_valid_nxt        = 1'b1;
        res_nxt.kind         = RES_RUN_DONE;
        res_nxt.vertex_color = '0;
        res_nxt.color_count  = OUT_COLOR_W'(top_nxt);
        res_nxt.overflow     = over_r;
        run_nxt              = 1'b0;
        row_cnt_nxt          = '0;
        edge_cnt_nxt         = '0;
        ord_cnt_nxt          = '0;
        state_nxt            = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    v_r      <= v_nxt;
    k_r      <= k_nxt;
    end_r    <= end_nxt;
    c_r      <= c_nxt;
    top_r    <= top_nxt;
    over_r   <= over_nxt;
    rd_oob_r <= rd_oob_nxt;
    res_r    <= res_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      run_r       <= 1'b0;
      idx_r       <= '0;
      row_cnt_r   <= '0;
      edge_cnt_r  <= '0;
      ord_cnt_r   <= '0;
      stamp_vld_r <= '0;
      sweep_vld_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      idx_r       <= idx_nxt;
      row_cnt_r   <= row_cnt_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      ord_cnt_r   <= ord_cnt_nxt;
      stamp_vld_r <= stamp_vld_nxt;
      sweep_vld_r <= sweep_vld_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  igc_ram #(.W(VAL_W), .D(MAX_VERTICES)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(value),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  igc_ram #(.W(VAL_W), .D(MAX_EDGE_ENTRIES)) u_adj_ram (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(value),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  igc_ram #(.W(VAL_W), .D(MAX_VERTICES)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(value),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  igc_ram #(.W(CW), .D(MAX_VERTICES)) u_col_ram (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata)
  );

  igc_ram #(.W(VW), .D(MAX_PALETTE)) u_stamp_ram (
    .clk(clk), .we(stamp_we), .waddr(stamp_waddr), .wdata(i_r[VW-1:0]),
    .raddr(stamp_raddr), .rdata(stamp_rdata)
  );

  a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |=> !res_valid_r)
    else $error("result strobe longer than one cycle");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLEAR && busy))
    else $error("no clearing pass after reset");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_S_RD || state_r == S_S_CHK) |-> c_r <= pal_eff)
    else $error("color search ran past palette");

  a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_V_ORD) |-> i_r <= n_eff)
    else $error("order walk ran past vertex count");

  a_run_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.kind == RES_RUN_DONE) |-> $past(state_r == S_SWEEP_END))
    else $error("run result outside sweep end");

endmodule
